FILE: design/uoi_pkg.sv
// Shared types, codes and constants for the unwind opcode interpreter.
package uoi_pkg;

	// item action codes
	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_OPCODE = 2'd2;
	localparam logic [1:0] ACT_END    = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_POP  = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_CANT  = 2'd1;
	localparam logic [1:0] ERR_BAD   = 2'd2;
	localparam logic [1:0] ERR_NOPC  = 2'd3;

	// fixed register numbers
	localparam logic [3:0] REG_SP = 4'd13;
	localparam logic [3:0] REG_LR = 4'd14;
	localparam logic [3:0] REG_PC = 4'd15;

	// opcode encodings
	localparam logic [7:0] OP_FINISH = 8'hB0;
	localparam logic [7:0] OP_LOWPOP = 8'hB1;
	localparam logic [7:0] OP_ULEB   = 8'hB2;
	localparam logic [31:0] ULEB_BIAS = 32'h0000_0204;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// opcode class, decoded from the first byte of an instruction
	typedef enum logic [3:0] {
		OPC_INC,
		OPC_DEC,
		OPC_MASK,
		OPC_LDVSP,
		OPC_POPR4,
		OPC_POPLR,
		OPC_FINISH,
		OPC_LOW,
		OPC_ULEB,
		OPC_BAD
	} uoi_opc_t;

	// one queued item with its class
	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  reg_index;
		logic [31:0] reg_value;
		logic [7:0]  opcode_byte;
		uoi_opc_t    op_class;
	} uoi_item_t;

endpackage

FILE: design/uoi_front.sv
// Front end: accepts items, classifies the opcode byte and queues them.
module uoi_front #(
	parameter int QueueDepth = uoi_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic [3:0]        reg_index,
	input  logic [31:0]       reg_value,
	input  logic [7:0]        opcode_byte,
	output logic              q_valid,
	output uoi_pkg::uoi_item_t q_item,
	input  logic              q_take
);

	localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CW = $clog2(QueueDepth + 1);

	uoi_pkg::uoi_item_t queue_q [QueueDepth];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      count_q;
	uoi_pkg::uoi_opc_t  opc;
	uoi_pkg::uoi_item_t new_item;
	logic               push, pop;

	// classify the first byte of an instruction
	always_comb begin
		opc = uoi_pkg::OPC_BAD;
		case (opcode_byte[7:6])
			2'b00: opc = uoi_pkg::OPC_INC;
			2'b01: opc = uoi_pkg::OPC_DEC;
			default: begin
				if (opcode_byte[7:4] == 4'h8) begin
					opc = uoi_pkg::OPC_MASK;
				end else if (opcode_byte[7:4] == 4'h9) begin
					// vsp from r13 or r15 is reserved
					if (opcode_byte[3:0] == uoi_pkg::REG_SP ||
					    opcode_byte[3:0] == uoi_pkg::REG_PC) begin
						opc = uoi_pkg::OPC_BAD;
					end else begin
						opc = uoi_pkg::OPC_LDVSP;
					end
				end else if (opcode_byte[7:3] == 5'b10100) begin
					opc = uoi_pkg::OPC_POPR4;
				end else if (opcode_byte[7:3] == 5'b10101) begin
					opc = uoi_pkg::OPC_POPLR;
				end else if (opcode_byte == uoi_pkg::OP_FINISH) begin
					opc = uoi_pkg::OPC_FINISH;
				end else if (opcode_byte == uoi_pkg::OP_LOWPOP) begin
					opc = uoi_pkg::OPC_LOW;
				end else if (opcode_byte == uoi_pkg::OP_ULEB) begin
					opc = uoi_pkg::OPC_ULEB;
				end else begin
					opc = uoi_pkg::OPC_BAD;
				end
			end
		endcase
	end

	always_comb begin
		new_item.action      = action;
		new_item.reg_index   = reg_index;
		new_item.reg_value   = reg_value;
		new_item.opcode_byte = opcode_byte;
		new_item.op_class    = opc;
	end

	assign in_ready = (count_q != CW'(QueueDepth));
	assign q_valid  = (count_q != '0);
	assign q_item   = queue_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_take && q_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/uoi_back.sv
// Back end: sequencer that executes queued items over the register file and vsp.
module uoi_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  uoi_pkg::uoi_item_t q_item,
	output logic               q_take,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [3:0]         pop_reg,
	output logic [31:0]        pop_address,
	output logic [1:0]         error_code,
	output logic [31:0]        final_sp,
	output logic [31:0]        final_pc,
	output logic               last
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RUN  = 2'd1;
	localparam logic [1:0] PH_FIN  = 2'd2;

	localparam logic [1:0] AW_NONE = 2'd0;
	localparam logic [1:0] AW_MASK = 2'd1;
	localparam logic [1:0] AW_LOW  = 2'd2;
	localparam logic [1:0] AW_ULEB = 2'd3;

	localparam logic [2:0] ULEB_LAST = 3'd4;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_START = 8'b0000_0010,
		S_LDVSP = 8'b0000_0100,
		S_POP   = 8'b0000_1000,
		S_C15   = 8'b0001_0000,
		S_C14   = 8'b0010_0000,
		S_CW    = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} bk_state_t;

	bk_state_t   state_q;
	logic [1:0]  phase_q, await_q;
	logic [3:0]  pend_q;
	logic [29:0] acc_q;
	logic [2:0]  ucnt_q;
	logic [15:0] mask_q;
	logic [31:0] vsp_q, pc_q;
	logic [1:0]  err_q, rkind_q;

	logic [31:0] rf_q [16];
	logic [31:0] rf_rd_q;
	logic        rf_we;
	logic [3:0]  rf_wa, rf_ra;
	logic [31:0] rf_wd;

	logic        ovalid_q, olast_q;
	logic [1:0]  okind_q, oerr_q;
	logic [3:0]  oreg_q;
	logic [31:0] oaddr_q, osp_q, opc_q;

	uoi_pkg::uoi_item_t it;
	logic [7:0]  b;
	logic        out_free, take;
	logic [3:0]  pop_idx;
	logic [15:0] mask_rest, first_mask, low_mask, range_mask;
	logic [7:0]  range_lo;
	logic [29:0] acc_next;
	logic [31:0] pc_sel;

	logic        res_load, res_last;
	logic [1:0]  res_kind, res_err;
	logic [3:0]  res_reg;
	logic [31:0] res_addr, res_sp, res_pc;

	// place a uleb128 digit at its bit position
	function automatic logic [29:0] uleb_part(input logic [6:0] bits, input logic [2:0] cnt);
		logic [36:0] wide;
		wide = {30'd0, bits};
		case (cnt)
			3'd0: wide = wide;
			3'd1: wide = wide << 7;
			3'd2: wide = wide << 14;
			3'd3: wide = wide << 21;
			3'd4: wide = wide << 28;
			default: wide = '0;
		endcase
		return wide[29:0];
	endfunction

	assign it       = q_item;
	assign b        = q_item.opcode_byte;
	assign out_free = !ovalid_q || out_ready;
	assign take     = (state_q == S_IDLE) && q_valid;
	assign q_take   = take;

	// lowest set bit of the pop mask
	always_comb begin
		pop_idx = '0;
		for (int i = 15; i >= 0; i--) begin
			if (mask_q[i]) begin
				pop_idx = 4'(i);
			end
		end
	end
	assign mask_rest = mask_q & (mask_q - 16'd1);

	// masks for the pop instructions
	assign first_mask = {pend_q, b, 4'b0000};
	assign low_mask   = {12'd0, b[3:0]};
	assign range_lo   = 8'hFF >> (3'd7 - b[2:0]);
	assign range_mask = {4'd0, range_lo, 4'd0};
	assign acc_next   = acc_q | uleb_part(b[6:0], ucnt_q);
	assign pc_sel     = (pc_q != '0) ? pc_q : rf_rd_q;

	// register file port control
	always_comb begin
		rf_we = 1'b0;
		rf_wa = it.reg_index;
		rf_wd = it.reg_value;
		rf_ra = uoi_pkg::REG_PC;
		case (state_q)
			S_IDLE: begin
				rf_we = take && (it.action == uoi_pkg::ACT_WRITE);
				if (it.action == uoi_pkg::ACT_START) begin
					rf_ra = uoi_pkg::REG_SP;
				end else if (it.action == uoi_pkg::ACT_OPCODE &&
				             it.op_class == uoi_pkg::OPC_LDVSP) begin
					rf_ra = b[3:0];
				end
			end
			S_START: begin
				rf_we = 1'b1;
				rf_wa = uoi_pkg::REG_PC;
				rf_wd = '0;
			end
			S_C15: rf_ra = uoi_pkg::REG_LR;
			S_C14: begin
				rf_we = 1'b1;
				rf_wa = uoi_pkg::REG_SP;
				rf_wd = vsp_q;
			end
			S_CW: begin
				rf_we = 1'b1;
				rf_wa = uoi_pkg::REG_PC;
				rf_wd = pc_q;
			end
			default: rf_we = 1'b0;
		endcase
	end

	// register file memory with registered read
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_q[rf_wa] <= rf_wd;
		end
		rf_rd_q <= rf_q[rf_ra];
	end

	// next result
	always_comb begin
		res_load = 1'b0;
		res_kind = uoi_pkg::KIND_POP;
		res_reg  = '0;
		res_addr = '0;
		res_err  = uoi_pkg::ERR_NONE;
		res_sp   = '0;
		res_pc   = '0;
		res_last = 1'b1;
		case (state_q)
			S_POP: begin
				res_load = out_free;
				res_reg  = pop_idx;
				res_addr = vsp_q;
				res_last = (mask_rest == '0);
			end
			S_EMIT: begin
				res_load = out_free;
				res_kind = rkind_q;
				if (rkind_q == uoi_pkg::KIND_DONE) begin
					res_sp = vsp_q;
					res_pc = pc_q;
				end else begin
					res_err = err_q;
				end
			end
			default: res_load = 1'b0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			phase_q  <= PH_IDLE;
			await_q  <= AW_NONE;
			pend_q   <= '0;
			acc_q    <= '0;
			ucnt_q   <= '0;
			mask_q   <= '0;
			vsp_q    <= '0;
			pc_q     <= '0;
			err_q    <= uoi_pkg::ERR_NONE;
			rkind_q  <= uoi_pkg::KIND_ERR;
			ovalid_q <= 1'b0;
		end else begin
			if (res_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (it.action)
							uoi_pkg::ACT_START: state_q <= S_START;
							uoi_pkg::ACT_OPCODE: begin
								if (phase_q == PH_RUN) begin
									case (await_q)
										AW_MASK: begin
											await_q <= AW_NONE;
											if (first_mask == '0) begin
												phase_q <= PH_FIN;
												err_q   <= uoi_pkg::ERR_CANT;
												rkind_q <= uoi_pkg::KIND_ERR;
												state_q <= S_EMIT;
											end else begin
												mask_q  <= first_mask;
												state_q <= S_POP;
											end
										end
										AW_LOW: begin
											await_q <= AW_NONE;
											if (b[7:4] != '0 || b[3:0] == '0) begin
												phase_q <= PH_FIN;
												err_q   <= uoi_pkg::ERR_BAD;
												rkind_q <= uoi_pkg::KIND_ERR;
												state_q <= S_EMIT;
											end else begin
												mask_q  <= low_mask;
												state_q <= S_POP;
											end
										end
										AW_ULEB: begin
											acc_q <= acc_next;
											if (!b[7]) begin
												await_q <= AW_NONE;
												vsp_q   <= vsp_q + uoi_pkg::ULEB_BIAS +
												           {acc_next, 2'b00};
											end else if (ucnt_q == ULEB_LAST) begin
												// too many continuation bytes
												phase_q <= PH_FIN;
												await_q <= AW_NONE;
												err_q   <= uoi_pkg::ERR_BAD;
												rkind_q <= uoi_pkg::KIND_ERR;
												state_q <= S_EMIT;
											end else begin
												ucnt_q <= ucnt_q + 3'd1;
											end
										end
										default: begin
											case (it.op_class)
												uoi_pkg::OPC_INC:
													vsp_q <= vsp_q + {24'd0, b[5:0], 2'b00} + 32'd4;
												uoi_pkg::OPC_DEC:
													vsp_q <= vsp_q - ({24'd0, b[5:0], 2'b00} + 32'd4);
												uoi_pkg::OPC_MASK: begin
													pend_q  <= b[3:0];
													await_q <= AW_MASK;
												end
												uoi_pkg::OPC_LDVSP: state_q <= S_LDVSP;
												uoi_pkg::OPC_POPR4: begin
													mask_q  <= range_mask;
													state_q <= S_POP;
												end
												uoi_pkg::OPC_POPLR: begin
													mask_q  <= range_mask | 16'h4000;
													state_q <= S_POP;
												end
												uoi_pkg::OPC_FINISH: begin
													phase_q <= PH_FIN;
													state_q <= S_C15;
												end
												uoi_pkg::OPC_LOW: begin
													pend_q  <= b[3:0];
													await_q <= AW_LOW;
												end
												uoi_pkg::OPC_ULEB: begin
													pend_q  <= b[3:0];
													await_q <= AW_ULEB;
													acc_q   <= '0;
													ucnt_q  <= '0;
												end
												default: begin
													phase_q <= PH_FIN;
													err_q   <= uoi_pkg::ERR_BAD;
													rkind_q <= uoi_pkg::KIND_ERR;
													state_q <= S_EMIT;
												end
											endcase
										end
									endcase
								end
							end
							uoi_pkg::ACT_END: begin
								if (phase_q == PH_RUN) begin
									phase_q <= PH_FIN;
									await_q <= AW_NONE;
									if (await_q != AW_NONE) begin
										// stream ends inside an instruction
										err_q   <= uoi_pkg::ERR_BAD;
										rkind_q <= uoi_pkg::KIND_ERR;
										state_q <= S_EMIT;
									end else begin
										state_q <= S_C15;
									end
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_START: begin
					// r13 read data is here; r15 cleared by the write port
					vsp_q   <= rf_rd_q;
					phase_q <= PH_RUN;
					await_q <= AW_NONE;
					pend_q  <= '0;
					acc_q   <= '0;
					ucnt_q  <= '0;
					state_q <= S_IDLE;
				end
				S_LDVSP: begin
					vsp_q   <= rf_rd_q;
					state_q <= S_IDLE;
				end
				S_POP: begin
					if (out_free) begin
						vsp_q  <= vsp_q + 32'd4;
						mask_q <= mask_rest;
						if (mask_rest == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_C15: begin
					pc_q    <= rf_rd_q;
					state_q <= S_C14;
				end
				S_C14: begin
					// r13 takes vsp here
					if (pc_sel == '0) begin
						err_q   <= uoi_pkg::ERR_NOPC;
						rkind_q <= uoi_pkg::KIND_ERR;
						state_q <= S_EMIT;
					end else begin
						pc_q    <= pc_sel;
						state_q <= S_CW;
					end
				end
				S_CW: begin
					rkind_q <= uoi_pkg::KIND_DONE;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			okind_q <= res_kind;
			oreg_q  <= res_reg;
			oaddr_q <= res_addr;
			oerr_q  <= res_err;
			osp_q   <= res_sp;
			opc_q   <= res_pc;
			olast_q <= res_last;
		end
	end

	assign out_valid   = ovalid_q;
	assign kind        = okind_q;
	assign pop_reg     = oreg_q;
	assign pop_address = oaddr_q;
	assign error_code  = oerr_q;
	assign final_sp    = osp_q;
	assign final_pc    = opc_q;
	assign last        = olast_q;

	// a pop sequence never starts with an empty mask
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> mask_q != '0)
		else $error("pop state with empty mask");

	// done and error results only after the run has ended
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> phase_q == PH_FIN)
		else $error("final result while run still active");

	// the final pop of a sequence is flagged last and frees the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP && out_free && mask_rest == '0
		|=> state_q == S_IDLE && ovalid_q && olast_q)
		else $error("last pop not flagged");

	// a continuation is only pending inside a run
	assert property (@(posedge clk) disable iff (!arst_n)
		await_q != AW_NONE |-> phase_q == PH_RUN)
		else $error("continuation pending outside a run");

endmodule

FILE: design/unwind_opcode_interpreter.sv
// Unwind opcode interpreter: item queue front end and sequencing back end.
// Items are registered in the queue; the sequencer takes one only when idle.
// A pop result passes the pop state and the output register; a done result the C15,
// C14, CW and emit states, then the output register. A pop instruction pops one
// register per cycle while the single output register is free.
// Reset clears control state and vsp; the register file is undefined until written.
module unwind_opcode_interpreter #(
	parameter int QueueDepth = uoi_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [3:0]  reg_index,
	input  logic [31:0] reg_value,
	input  logic [7:0]  opcode_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  pop_reg,
	output logic [31:0] pop_address,
	output logic [1:0]  error_code,
	output logic [31:0] final_sp,
	output logic [31:0] final_pc,
	output logic        last
);

	logic               q_valid, q_take;
	uoi_pkg::uoi_item_t q_item;

	uoi_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.reg_index   (reg_index),
		.reg_value   (reg_value),
		.opcode_byte (opcode_byte),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_take      (q_take)
	);

	uoi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_take      (q_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.pop_reg     (pop_reg),
		.pop_address (pop_address),
		.error_code  (error_code),
		.final_sp    (final_sp),
		.final_pc    (final_pc),
		.last        (last)
	);

endmodule

FILE: tb/unwind_opcode_interpreter_tb.sv
// Self-checking testbench for the unwind opcode interpreter.
`timescale 1ns / 1ps

module unwind_opcode_interpreter_tb;
	import uoi_pkg::*;

	localparam int RANDOM_ITEMS = 270;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 40;

	// opcode class masks and values
	localparam logic [7:0] OPM_ADJ     = 8'hC0;
	localparam logic [7:0] OPV_INC     = 8'h00;
	localparam logic [7:0] OPV_DEC     = 8'h40;
	localparam logic [7:0] OPM_NIBBLE  = 8'hF0;
	localparam logic [7:0] OPV_MASKPOP = 8'h80;
	localparam logic [7:0] OPV_LDVSP   = 8'h90;
	localparam logic [7:0] OPM_POP     = 8'hF8;
	localparam logic [7:0] OPV_POPR4   = 8'hA0;
	localparam logic [7:0] OPV_POPLR   = 8'hA8;

	typedef enum logic [1:0] {FOLLOW_NONE, FOLLOW_MASK, FOLLOW_LOW, FOLLOW_ULEB} follow_t;
	typedef enum logic [1:0] {RUN_IDLE, RUN_ACTIVE, RUN_DONE} run_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  pop_reg;
		logic [31:0] pop_address;
		logic [1:0]  error_code;
		logic [31:0] final_sp;
		logic [31:0] final_pc;
		logic        last;
	} unwind_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [3:0]  reg_index;
	logic [31:0] reg_value;
	logic [7:0]  opcode_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [3:0]  pop_reg;
	logic [31:0] pop_address;
	logic [1:0]  error_code;
	logic [31:0] final_sp;
	logic [31:0] final_pc;
	logic        last;

	// predicted interpreter state
	logic [31:0] regs [16];
	logic [31:0] vsp;
	logic [7:0]  held_op;
	follow_t     follow_state;
	logic [34:0] uleb_value;
	logic [5:0]  uleb_bits;
	run_t        run_state;

	unwind_result_t unwind_results_due[$];
	unwind_result_t staged;
	unwind_result_t want;
	bit             staged_valid;
	logic [3:0]     popped_now[$];
	int             live_items;
	int             failures;
	bit             steady;
	bit             hold_request;

	unwind_opcode_interpreter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.opcode_byte(opcode_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.pop_reg(pop_reg),
		.pop_address(pop_address),
		.error_code(error_code),
		.final_sp(final_sp),
		.final_pc(final_pc),
		.last(last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// results of one item are staged so the final one can carry last
	task automatic emit_result(input logic [1:0] k, input logic [3:0] r, input logic [31:0] addr,
			input logic [1:0] err, input logic [31:0] sp, input logic [31:0] pc);
		if (staged_valid)
			unwind_results_due.push_back(staged);
		staged = '{k, r, addr, err, sp, pc, 1'b0};
		staged_valid = 1'b1;
	endtask

	task automatic raise_error(input logic [1:0] code);
		run_state = RUN_DONE;
		follow_state = FOLLOW_NONE;
		emit_result(KIND_ERR, '0, '0, code, '0, '0);
	endtask

	task automatic pop_mask(input logic [15:0] m);
		for (int r = 0; r < 16; r++) begin
			if (m[r]) begin
				emit_result(KIND_POP, 4'(r), vsp, ERR_NONE, '0, '0);
				popped_now.push_back(4'(r));
				vsp += 32'd4;
			end
		end
	endtask

	// sp takes vsp; pc is the popped r15, else lr
	task automatic commit_run();
		logic [31:0] pc;
		regs[REG_SP] = vsp;
		pc = (regs[REG_PC] != 0) ? regs[REG_PC] : regs[REG_LR];
		if (pc == 0) begin
			raise_error(ERR_NOPC);
		end else begin
			regs[REG_PC] = pc;
			run_state = RUN_DONE;
			follow_state = FOLLOW_NONE;
			emit_result(KIND_DONE, '0, '0, ERR_NONE, vsp, pc);
		end
	endtask

	// second byte of a two-byte instruction or a uleb128 byte
	task automatic follow_byte(input logic [7:0] b);
		logic [15:0] m;
		case (follow_state)
			FOLLOW_MASK: begin
				follow_state = FOLLOW_NONE;
				m = {held_op[3:0], b, 4'b0000};
				if (m == 0)
					raise_error(ERR_CANT);
				else
					pop_mask(m);
			end
			FOLLOW_LOW: begin
				follow_state = FOLLOW_NONE;
				if (b[7:4] != 0 || b[3:0] == 0)
					raise_error(ERR_BAD);
				else
					pop_mask({12'b0, b[3:0]});
			end
			default: begin
				uleb_value = uleb_value | (35'(b[6:0]) << uleb_bits[4:0]);
				if (!b[7]) begin
					follow_state = FOLLOW_NONE;
					vsp += ULEB_BIAS + {uleb_value[29:0], 2'b00};
				end else begin
					uleb_bits += 6'd7;
					if (uleb_bits >= 6'd32)
						raise_error(ERR_BAD);
				end
			end
		endcase
	endtask

	task automatic decode_byte(input logic [7:0] b);
		int cnt;
		logic [15:0] m;
		cnt = b[2:0] + 1;
		m = 16'(((1 << cnt) - 1) << 4);
		if (follow_state != FOLLOW_NONE) begin
			follow_byte(b);
		end else if ((b & OPM_ADJ) == OPV_INC) begin
			vsp += {24'b0, b[5:0], 2'b00} + 32'd4;
		end else if ((b & OPM_ADJ) == OPV_DEC) begin
			vsp -= {24'b0, b[5:0], 2'b00} + 32'd4;
		end else if ((b & OPM_NIBBLE) == OPV_MASKPOP) begin
			held_op = b;
			follow_state = FOLLOW_MASK;
		end else if ((b & OPM_NIBBLE) == OPV_LDVSP) begin
			if (b[3:0] == REG_SP || b[3:0] == REG_PC)
				raise_error(ERR_BAD);
			else
				vsp = regs[b[3:0]];
		end else if ((b & OPM_POP) == OPV_POPR4) begin
			pop_mask(m);
		end else if ((b & OPM_POP) == OPV_POPLR) begin
			pop_mask(m | (16'd1 << REG_LR));
		end else if (b == OP_FINISH) begin
			commit_run();
		end else if (b == OP_LOWPOP) begin
			held_op = b;
			follow_state = FOLLOW_LOW;
		end else if (b == OP_ULEB) begin
			held_op = b;
			follow_state = FOLLOW_ULEB;
			uleb_value = '0;
			uleb_bits = '0;
		end else begin
			raise_error(ERR_BAD);
		end
	endtask

	// predicts the results of one accepted item
	task automatic interpret_item(input logic [1:0] act, input logic [3:0] idx,
			input logic [31:0] val, input logic [7:0] b);
		popped_now.delete();
		staged_valid = 1'b0;
		if (act == ACT_WRITE || act == ACT_START || run_state == RUN_ACTIVE)
			live_items++;
		if (act == ACT_WRITE) begin
			regs[idx] = val;
		end else if (act == ACT_START) begin
			vsp = regs[REG_SP];
			regs[REG_PC] = '0;
			held_op = '0;
			follow_state = FOLLOW_NONE;
			uleb_value = '0;
			uleb_bits = '0;
			run_state = RUN_ACTIVE;
		end else if (run_state == RUN_ACTIVE) begin
			if (act == ACT_OPCODE)
				decode_byte(b);
			else if (follow_state != FOLLOW_NONE)
				raise_error(ERR_BAD);
			else
				commit_run();
		end
		if (staged_valid) begin
			staged.last = 1'b1;
			unwind_results_due.push_back(staged);
			staged_valid = 1'b0;
		end
	endtask

	// drives one item and waits for it to be taken
	task automatic send_item(input logic [1:0] act, input logic [3:0] idx,
			input logic [31:0] val, input logic [7:0] b);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		reg_index <= idx;
		reg_value <= val;
		opcode_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		interpret_item(act, idx, val, b);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(ACT_OPCODE, 4'($urandom), $urandom, b);
	endtask

	task automatic send_write(input logic [3:0] idx, input logic [31:0] val);
		send_item(ACT_WRITE, idx, val, 8'($urandom));
	endtask

	task automatic send_start();
		send_item(ACT_START, 4'($urandom), $urandom, 8'($urandom));
	endtask

	task automatic send_end();
		send_item(ACT_END, 4'($urandom), $urandom, 8'($urandom));
	endtask

	// opcode byte followed by the host loading every popped word back
	task automatic send_byte_restore(input logic [7:0] b);
		logic [3:0] loaded[$];
		logic [31:0] word;
		send_byte(b);
		loaded = popped_now;
		foreach (loaded[i]) begin
			word = (loaded[i] == REG_PC && $urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
			send_write(loaded[i], word);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (unwind_results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// every register written once, extremes included
	task automatic test_register_load();
		send_write(4'd0, 32'h0000_0000);
		send_write(4'd1, 32'hFFFF_FFFF);
		send_write(4'd4, 32'hFFFF_FFF0);
		for (int r = 2; r < 16; r++) begin
			if (r != 4 && r != REG_SP && r != REG_LR && r != REG_PC)
				send_write(4'(r), $urandom);
		end
		send_write(REG_SP, 32'h0000_0008);
		send_write(REG_LR, 32'h8000_0001);
		send_write(REG_PC, 32'h0000_0000);
		drain();
	endtask

	// every instruction but the mask pop, in a single run
	task automatic test_opcodes();
		send_byte(8'h00);
		send_end();
		send_start();
		send_byte(8'h00);
		send_byte(8'h3F);
		send_byte(8'h40);
		send_byte(8'h7F);
		send_byte(8'h94);
		send_byte(8'hA7);
		send_byte(8'hAF);
		send_byte(OP_LOWPOP);
		send_byte(8'h0F);
		send_byte(OP_ULEB);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(OP_FINISH);
		// finished run ignores further bytes
		send_byte(OP_FINISH);
		send_end();
		drain();
	endtask

	task automatic test_bad_opcodes();
		// zero mask refuses to unwind
		send_start();
		send_byte(8'h80);
		send_byte(8'h00);
		// full mask, twelve pops, then end commits with lr
		send_start();
		send_byte(8'h8F);
		send_byte(8'hFF);
		send_end();
		send_start();
		send_byte(8'h9D);
		send_start();
		send_byte(8'h9F);
		send_start();
		send_byte(8'hB3);
		send_start();
		send_byte(8'hFF);
		// low pop with zero mask, then with high nibble set
		send_start();
		send_byte(OP_LOWPOP);
		send_byte(8'h00);
		send_start();
		send_byte(OP_LOWPOP);
		send_byte(8'h10);
		// continuation on the fifth uleb128 byte
		send_start();
		send_byte(OP_ULEB);
		repeat (5) send_byte(8'h80);
		drain();
	endtask

	task automatic test_stream_ends();
		// end while a second byte or uleb128 byte is awaited
		send_start();
		send_byte(OP_LOWPOP);
		send_end();
		send_start();
		send_byte(8'h80);
		send_end();
		send_start();
		send_byte(OP_ULEB);
		send_byte(8'h81);
		send_end();
		// neither pc nor lr
		send_start();
		send_write(REG_LR, 32'h0);
		send_end();
		send_write(REG_LR, 32'h0000_4001);
		// restart drops the pending continuation; a written pc wins over lr
		send_start();
		send_byte(OP_LOWPOP);
		send_start();
		send_byte(8'hA8);
		send_write(REG_PC, 32'h0000_1234);
		send_byte(OP_FINISH);
		drain();
	endtask

	// receiver holds off while full-mask pops keep coming
	task automatic test_backpressure();
		steady = 1'b1;
		hold_request = 1'b1;
		send_start();
		repeat (4) begin
			send_byte(8'h8F);
			send_byte(8'hFF);
		end
		send_byte(8'hAF);
		send_byte(OP_FINISH);
		steady = 1'b0;
		drain();
	endtask

	// mostly well-formed runs with random content, some noise and broken sequences
	task automatic test_random();
		int n_instr;
		int nb;
		logic [7:0] b;
		while (live_items < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 99) < 15);
			if ($urandom_range(0, 9) == 0) begin
				send_item(2'($urandom), 4'($urandom), $urandom, 8'($urandom));
				continue;
			end
			if ($urandom_range(0, 3) == 0)
				send_write(REG_SP, $urandom);
			send_start();
			n_instr = $urandom_range(1, 8);
			for (int k = 0; k < n_instr && run_state == RUN_ACTIVE; k++) begin
				case ($urandom_range(0, 9))
					0: send_byte_restore(OPV_INC | 8'($urandom_range(0, 63)));
					1: send_byte_restore(OPV_DEC | 8'($urandom_range(0, 63)));
					2: begin
						send_byte(OPV_MASKPOP | 8'($urandom_range(0, 15)));
						if ($urandom_range(0, 19) != 0) begin
							b = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
							send_byte_restore(b);
						end
					end
					3: send_byte_restore(OPV_LDVSP | 8'($urandom_range(0, 15)));
					4: send_byte_restore(OPV_POPR4 | 8'($urandom_range(0, 7)));
					5: send_byte_restore(OPV_POPLR | 8'($urandom_range(0, 7)));
					6: begin
						send_byte(OP_LOWPOP);
						if ($urandom_range(0, 19) != 0) begin
							b = ($urandom_range(0, 6) == 0) ? 8'($urandom)
								: 8'($urandom_range(1, 15));
							send_byte_restore(b);
						end
					end
					7: begin
						send_byte(OP_ULEB);
						nb = $urandom_range(1, 5);
						for (int j = 0; j < nb && run_state == RUN_ACTIVE; j++) begin
							if (j < nb - 1)
								b = {1'b1, 7'($urandom)};
							else if (j == 4)
								b = 8'($urandom);
							else
								b = {1'b0, 7'($urandom)};
							send_byte(b);
						end
					end
					8: send_write(4'($urandom_range(REG_LR, REG_PC)),
						($urandom_range(0, 2) == 0) ? 32'd0 : $urandom);
					default: send_byte_restore(8'($urandom));
				endcase
			end
			if (run_state == RUN_ACTIVE) begin
				nb = $urandom_range(0, 9);
				if (nb < 5)
					send_byte(OP_FINISH);
				else if (nb < 9)
					send_end();
			end
		end
		steady = 1'b0;
		drain();
	endtask

	// result side: random stalls plus one long hold on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			int rx_gap;
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (rx_gap > 0) begin
				out_ready <= 1'b0;
				rx_gap--;
			end else begin
				out_ready <= 1'b1;
				rx_gap = steady ? 0 : pick_gap();
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
			failures++;
		end
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (unwind_results_due.size() == 0) begin
				$display("%0t: unexpected result kind %0d reg %0d addr %h", $time, kind,
					pop_reg, pop_address);
				failures++;
			end else begin
				want = unwind_results_due.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("pop_reg", 32'(want.pop_reg), 32'(pop_reg));
				check_field("pop_address", want.pop_address, pop_address);
				check_field("error_code", 32'(want.error_code), 32'(error_code));
				check_field("final_sp", want.final_sp, final_sp);
				check_field("final_pc", want.final_pc, final_pc);
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	initial begin
		#20ms;
		$display("unwind_opcode_interpreter: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_WRITE;
		reg_index = '0;
		reg_value = '0;
		opcode_byte = '0;
		steady = 1'b0;
		hold_request = 1'b0;
		failures = 0;
		live_items = 0;
		staged_valid = 1'b0;
		for (int r = 0; r < 16; r++)
			regs[r] = '0;
		vsp = '0;
		held_op = '0;
		follow_state = FOLLOW_NONE;
		uleb_value = '0;
		uleb_bits = '0;
		run_state = RUN_IDLE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_load();
		test_opcodes();
		test_bad_opcodes();
		test_stream_ends();
		test_backpressure();
		live_items = 0;
		test_random();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("unwind_opcode_interpreter: match");
		else
			$display("unwind_opcode_interpreter: mismatch");
		$finish;
	end

endmodule
